@@ sv/afc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// afc_pkg: shared types and constants of the box/frustum classifier
// Fixed-point widths, visibility codes and the word handed from cell to cell.
// ----------------------------------------------------------------------------
package afc_pkg;

  // default number of planes in the chain
  localparam int unsigned NumPlanesDef = 6;

  // coordinate and plane word widths
  localparam int unsigned CoordW = 16;
  localparam int unsigned PlaneW = 4 * CoordW;
  localparam int unsigned ProdW  = 2 * CoordW;
  // d is aligned to the Q2.14 * Q8.8 product scale
  localparam int unsigned DShift = 14;
  // three products plus the aligned d term, with headroom
  localparam int unsigned AccW   = ProdW + 3;

  // visibility codes
  localparam logic [1:0] VisInside  = 2'd0;
  localparam logic [1:0] VisCross   = 2'd1;
  localparam logic [1:0] VisOutside = 2'd2;

  // word passed along the chain: box corners and running verdict
  typedef struct packed {
    logic [2:0][CoordW-1:0] lo;
    logic [2:0][CoordW-1:0] hi;
    logic [1:0]             vis;
  } afc_word_t;

endpackage : afc_pkg
`default_nettype wire

@@ sv/aabb_frustum_classifier.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_frustum_classifier: box against frustum planes
// Chain of plane cells; each box flows through all cells and leaves with a
// visibility verdict.
// ----------------------------------------------------------------------------
// Usage:
//   Planes are loaded through cfg_we_i / cfg_idx_i / cfg_data_i, one 64-bit
//   word per plane (a, b, c in Q2.14 at bits 47:0, d in Q8.8 at bits 63:48).
//   Indexes at or beyond NUM_PLANES are dropped. Load planes while idle.
//   A box word is taken at each edge with start_i high and busy_o low; busy_o
//   is always low, so one box can enter every cycle.
//   Each cell registers its products, then its sum and compare, so the
//   verdict appears on visibility_o with done_o high once the box has passed
//   through every cell, in order; throughput is one box per cycle.
//   done_o is a one-cycle strobe and the receiver cannot stall it.
//   Reset clears all planes to zero (every box then reads as intersecting)
//   and empties the chain.
// ----------------------------------------------------------------------------
module aabb_frustum_classifier #(
  parameter int unsigned NUM_PLANES = afc_pkg::NumPlanesDef,
  localparam int unsigned IdxW = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [IdxW-1:0]                   cfg_idx_i,
  input  wire logic [afc_pkg::PlaneW-1:0]        cfg_data_i,
  input  wire logic                              start_i,
  input  wire logic signed [afc_pkg::CoordW-1:0] min_x_i,
  input  wire logic signed [afc_pkg::CoordW-1:0] min_y_i,
  input  wire logic signed [afc_pkg::CoordW-1:0] min_z_i,
  input  wire logic signed [afc_pkg::CoordW-1:0] max_x_i,
  input  wire logic signed [afc_pkg::CoordW-1:0] max_y_i,
  input  wire logic signed [afc_pkg::CoordW-1:0] max_z_i,
  output logic                                   busy_o,
  output logic                                   done_o,
  output logic [1:0]                             visibility_o
);
  import afc_pkg::*;

  logic      chain_valid [NUM_PLANES+1];
  afc_word_t chain_word  [NUM_PLANES+1];

  // chain head: incoming box with a clean verdict
  assign chain_valid[0] = start_i;
  assign chain_word[0]  = {min_z_i, min_y_i, min_x_i, max_z_i, max_y_i, max_x_i, VisInside};

  // one cell per plane
  for (genvar i = 0; i < NUM_PLANES; i++) begin : g_cell
    logic cell_we;
    assign cell_we = cfg_we_i && (cfg_idx_i == IdxW'(i));

    afc_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cfg_we_i    (cell_we),
      .cfg_data_i  (cfg_data_i),
      .in_valid_i  (chain_valid[i]),
      .in_word_i   (chain_word[i]),
      .out_valid_o (chain_valid[i+1]),
      .out_word_o  (chain_word[i+1])
    );
  end

  // fully pipelined, never holds off a new box
  assign busy_o       = 1'b0;
  assign done_o       = chain_valid[NUM_PLANES];
  assign visibility_o = chain_word[NUM_PLANES].vis;

endmodule : aabb_frustum_classifier
`default_nettype wire

@@ sv/afc_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// afc_cell: one plane of the classifier chain
// Holds one plane, tests the passing box against it in two stages and merges
// the verdict into the word before handing it to the next cell.
// ----------------------------------------------------------------------------
module afc_cell (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [afc_pkg::PlaneW-1:0]  cfg_data_i,
  input  wire logic                        in_valid_i,
  input  wire afc_pkg::afc_word_t          in_word_i,
  output logic                             out_valid_o,
  output afc_pkg::afc_word_t               out_word_o
);
  import afc_pkg::*;

  logic [PlaneW-1:0]            plane_q;

  logic                         mul_valid_q;
  afc_word_t                    mul_word_q;
  logic signed [2:0][ProdW-1:0] far_p_d, far_p_q;
  logic signed [2:0][ProdW-1:0] near_p_d, near_p_q;
  logic signed [AccW-1:0]       d_term_d, d_term_q;

  logic signed [AccW-1:0]       far_e;
  logic signed [AccW-1:0]       near_e;
  logic                         is_out;
  logic                         is_cross;

  logic                         out_valid_q;
  afc_word_t                    out_word_d, out_word_q;

  // plane register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q <= '0;
    end else if (cfg_we_i) begin
      plane_q <= cfg_data_i;
    end
  end

  // stage one: products, far/near picked by the normal sign
  always_comb begin
    logic signed [CoordW-1:0] n;
    logic signed [CoordW-1:0] lo_c;
    logic signed [CoordW-1:0] hi_c;
    logic signed [ProdW-1:0]  p_lo;
    logic signed [ProdW-1:0]  p_hi;
    logic                     pos;
    logic [CoordW-1:0]        d_raw;
    for (int k = 0; k < 3; k++) begin
      n    = plane_q[k*CoordW +: CoordW];
      lo_c = in_word_i.lo[k];
      hi_c = in_word_i.hi[k];
      p_lo = n * lo_c;
      p_hi = n * hi_c;
      pos  = !n[CoordW-1] && (|n);
      far_p_d[k]  = pos ? p_hi : p_lo;
      near_p_d[k] = pos ? p_lo : p_hi;
    end
    d_raw    = plane_q[3*CoordW +: CoordW];
    d_term_d = {{(AccW-CoordW-DShift){d_raw[CoordW-1]}}, d_raw, {DShift{1'b0}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else begin
      mul_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_word_q <= in_word_i;
    far_p_q    <= far_p_d;
    near_p_q   <= near_p_d;
    d_term_q   <= d_term_d;
  end

  // stage two: plane distances and verdict merge
  always_comb begin
    far_e  = d_term_q + AccW'($signed(far_p_q[0])) + AccW'($signed(far_p_q[1]))
           + AccW'($signed(far_p_q[2]));
    near_e = d_term_q + AccW'($signed(near_p_q[0])) + AccW'($signed(near_p_q[1]))
           + AccW'($signed(near_p_q[2]));
    is_out   = far_e[AccW-1];
    is_cross = near_e[AccW-1] || !(|near_e);

    out_word_d = mul_word_q;
    if (mul_word_q.vis == VisOutside || is_out) begin
      out_word_d.vis = VisOutside;
    end else if (mul_word_q.vis == VisCross || is_cross) begin
      out_word_d.vis = VisCross;
    end else begin
      out_word_d.vis = VisInside;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule : afc_cell
`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: box against frustum planes
// Loads plane sets through the register port and streams boxes into the
// classifier with varying gaps. A local model computes each verdict when the
// box is taken, and every done strobe is checked against the oldest verdict
// still pending.
// ----------------------------------------------------------------------------
module testbench;
  import afc_pkg::*;

  localparam int unsigned NumPlanes     = NumPlanesDef;
  localparam int unsigned IdxW          = (NumPlanes > 1) ? $clog2(NumPlanes) : 1;
  localparam int unsigned Latency       = 2 * NumPlanes;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned ResetCycles   = 6;
  // 1.0 in Q2.14
  localparam int          UnitNormal    = 16384;
  // half width of the directed test cube, 16.0 in Q8.8
  localparam int          CubeHalf      = 4096;

  typedef enum logic [1:0] {
    PlanesFrustum,
    PlanesMixed
  } plane_set_e;

  typedef struct packed {
    logic [2:0][CoordW-1:0] lo;
    logic [2:0][CoordW-1:0] hi;
  } box_t;

  // dut ports
  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [IdxW-1:0]          cfg_idx_i;
  logic [PlaneW-1:0]        cfg_data_i;
  logic                     start_i;
  logic signed [CoordW-1:0] min_x_i, min_y_i, min_z_i;
  logic signed [CoordW-1:0] max_x_i, max_y_i, max_z_i;
  logic                     busy_o;
  logic                     done_o;
  logic [1:0]               visibility_o;

  // model state: plane registers and verdicts waiting for their done strobe
  logic [PlaneW-1:0] plane_model [NumPlanes];
  logic [1:0]        vis_expect_q [$];
  int unsigned       fail_count;
  int unsigned       quiet_cycles;

  aabb_frustum_classifier #(
    .NUM_PLANES(NumPlanes)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .start_i     (start_i),
    .min_x_i     (min_x_i),
    .min_y_i     (min_y_i),
    .min_z_i     (min_z_i),
    .max_x_i     (max_x_i),
    .max_y_i     (max_y_i),
    .max_z_i     (max_z_i),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .visibility_o(visibility_o)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // exact verdict of one box against the current planes
  function automatic logic [1:0] classify_box(box_t b);
    logic [1:0] verdict;
    longint     far_e, near_e, nrm, lo_c, hi_c;
    verdict = VisInside;
    for (int p = 0; p < NumPlanes; p++) begin
      if (verdict != VisOutside) begin
        far_e  = longint'($signed(plane_model[p][3*CoordW +: CoordW])) * (1 << DShift);
        near_e = far_e;
        for (int k = 0; k < 3; k++) begin
          nrm  = longint'($signed(plane_model[p][k*CoordW +: CoordW]));
          lo_c = longint'($signed(b.lo[k]));
          hi_c = longint'($signed(b.hi[k]));
          // positive normal: max corner is the far one
          if (nrm > 0) begin
            far_e  += nrm * hi_c;
            near_e += nrm * lo_c;
          end else begin
            far_e  += nrm * lo_c;
            near_e += nrm * hi_c;
          end
        end
        if (far_e < 0) begin
          verdict = VisOutside;
        end else if (near_e <= 0) begin
          verdict = VisCross;
        end
      end
    end
    return verdict;
  endfunction

  function automatic logic [PlaneW-1:0] pack_plane(int a, int b, int c, int d);
    return {d[CoordW-1:0], c[CoordW-1:0], b[CoordW-1:0], a[CoordW-1:0]};
  endfunction

  function automatic box_t make_box(int lx, int ly, int lz, int hx, int hy, int hz);
    box_t b;
    b.lo[0] = lx[CoordW-1:0];
    b.lo[1] = ly[CoordW-1:0];
    b.lo[2] = lz[CoordW-1:0];
    b.hi[0] = hx[CoordW-1:0];
    b.hi[1] = hy[CoordW-1:0];
    b.hi[2] = hz[CoordW-1:0];
    return b;
  endfunction

  // mostly small boxes near the origin, some raw bit patterns, some inverted
  function automatic box_t rand_box();
    box_t        b;
    int          ctr, half;
    int unsigned pick, ax;
    logic [CoordW-1:0] tmp;
    pick = $urandom_range(0, 99);
    for (int k = 0; k < 3; k++) begin
      if (pick >= 75 && pick < 90) begin
        b.lo[k] = CoordW'($urandom);
        b.hi[k] = CoordW'($urandom);
      end else begin
        ctr     = int'($urandom_range(0, 'h6000)) - 'h3000;
        half    = int'($urandom_range(0, 'h0C00));
        b.lo[k] = CoordW'(ctr - half);
        b.hi[k] = CoordW'(ctr + half);
      end
    end
    // min above max on one axis
    if (pick >= 90) begin
      ax       = $urandom_range(0, 2);
      tmp      = b.lo[ax];
      b.lo[ax] = b.hi[ax];
      b.hi[ax] = tmp;
    end
    return b;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // one register write, then the write enable dropped again
  task automatic write_plane(input int unsigned idx, input logic [PlaneW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= IdxW'(idx);
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx < NumPlanes) begin
      plane_model[idx] = data;
    end
  endtask

  // offer one box word and hold it until taken
  task automatic send_box(input box_t b, input int unsigned idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    min_x_i <= b.lo[0];
    min_y_i <= b.lo[1];
    min_z_i <= b.lo[2];
    max_x_i <= b.hi[0];
    max_y_i <= b.hi[1];
    max_z_i <= b.hi[2];
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    vis_expect_q.push_back(classify_box(b));
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    while (vis_expect_q.size() != 0) @(posedge clk_i);
  endtask

  // planes as left by reset: every box reads as intersecting
  task automatic test_reset_planes();
    send_box(make_box(0, 0, 0, 0, 0, 0), 0);
    send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767), 0);
    send_box(make_box(32767, 32767, 32767, -32768, -32768, -32768), 0);
    send_box(rand_box(), 0);
    send_box(rand_box(), 0);
  endtask

  // axis aligned cube, exact touching cases on its faces
  task automatic test_axis_planes();
    drain_results();
    write_plane(0, pack_plane(UnitNormal, 0, 0, CubeHalf));
    write_plane(1, pack_plane(-UnitNormal, 0, 0, CubeHalf));
    write_plane(2, pack_plane(0, UnitNormal, 0, CubeHalf));
    write_plane(3, pack_plane(0, -UnitNormal, 0, CubeHalf));
    write_plane(4, pack_plane(0, 0, UnitNormal, CubeHalf));
    write_plane(5, pack_plane(0, 0, -UnitNormal, CubeHalf));
    // well inside
    send_box(make_box(-256, -256, -256, 256, 256, 256), 0);
    // near corner exactly on a face
    send_box(make_box(-CubeHalf, -256, -256, 256, 256, 256), 0);
    // far corner exactly on a face from outside
    send_box(make_box(-8192, -256, -256, -CubeHalf, 256, 256), 0);
    // one step beyond that face
    send_box(make_box(-8192, -256, -256, -CubeHalf - 1, 256, 256), 0);
    // straddles the upper z face
    send_box(make_box(-256, -256, 0, 256, 256, 8192), 0);
    // covers the whole cube
    send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767), 0);
    send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768), 0);
    send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767), 0);
    // inverted axes, used without a swap
    send_box(make_box(512, -256, -256, -512, 256, 256), 0);
    send_box(make_box(8192, -256, -256, -8192, 256, 256), 0);
    send_box(make_box(-256, CubeHalf, -256, 256, -256, 256), 0);
  endtask

  // extreme register contents and writes beyond the last plane
  task automatic test_register_extremes();
    drain_results();
    write_plane(0, {PlaneW{1'b1}});
    write_plane(1, pack_plane('h8000, 'h7FFF, 'h8000, 'h7FFF));
    write_plane(2, pack_plane('h7FFF, 0, 0, 'h7FFF));
    write_plane(3, pack_plane(0, 'h8000, 0, 'h7FFF));
    write_plane(4, '0);
    write_plane(5, pack_plane(0, 0, 'h7FFF, 'h7FFF));
    send_box(make_box(0, 0, 0, 0, 0, 0), 0);
    send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767), 0);
    send_box(make_box(-256, 32767, -32768, -256, 32767, -32768), 0);
    // these must not land in any plane
    drain_results();
    write_plane(NumPlanes, pack_plane('h8000, 'h8000, 'h8000, 'h8000));
    write_plane((1 << IdxW) - 1, {PlaneW{1'b1}});
    send_box(make_box(0, 0, 0, 0, 0, 0), 0);
    send_box(make_box(32767, -32768, 0, 32767, -32768, 0), 0);
  endtask

  // random plane set, then a long stream of boxes
  task automatic test_box_stream(input plane_set_e set, input int unsigned idle_pct,
                                 input int unsigned n_boxes, input int unsigned pause_every);
    int unsigned kind;
    int          na, nb, nc, nd;
    drain_results();
    for (int unsigned p = 0; p < NumPlanes; p++) begin
      kind = (set == PlanesFrustum) ? 0 : $urandom_range(0, 99);
      na   = int'($urandom_range(0, 2 * UnitNormal)) - UnitNormal;
      nb   = int'($urandom_range(0, 2 * UnitNormal)) - UnitNormal;
      nc   = int'($urandom_range(0, 2 * UnitNormal)) - UnitNormal;
      nd   = int'($urandom_range(0, 'h3000));
      if (kind < 50) begin
        // origin on the inner side
        write_plane(p, pack_plane(na, nb, nc, nd));
      end else if (kind < 70) begin
        write_plane(p, {$urandom, $urandom});
      end else if (kind < 85) begin
        write_plane(p, '0);
      end else begin
        write_plane(p, pack_plane($urandom_range(0, 1) ? 'h7FFF : 'h8000,
                                  $urandom_range(0, 1) ? 'h7FFF : 'h8000,
                                  $urandom_range(0, 1) ? 'h7FFF : 'h8000,
                                  $urandom_range(0, 1) ? 'h7FFF : 'h8000));
      end
    end
    for (int unsigned i = 0; i < n_boxes; i++) begin
      if (pause_every != 0 && i != 0 && i % pause_every == 0) begin
        drain_results();
      end
      // every fourth burst of 32 boxes goes back to back
      send_box(rand_box(), ((i / 32) % 4 == 3) ? 0 : idle_pct);
    end
  endtask

  // compare each done word with the oldest pending verdict
  always @(posedge clk_i) begin : check_results
    logic [1:0] want;
    if (rst_ni && done_o) begin
      if (vis_expect_q.size() == 0) begin
        report_mismatch($sformatf("visibility %0d with no box pending", visibility_o));
      end else begin
        want = vis_expect_q.pop_front();
        if (visibility_o !== want) begin
          report_mismatch($sformatf("visibility %0d, expected %0d", visibility_o, want));
        end
      end
    end
  end

  // watchdog on cycles with no traffic at all
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    fail_count = 0;
    for (int p = 0; p < NumPlanes; p++) begin
      plane_model[p] = '0;
    end
    rst_ni     <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= '0;
    cfg_data_i <= '0;
    start_i    <= 1'b0;
    min_x_i    <= '0;
    min_y_i    <= '0;
    min_z_i    <= '0;
    max_x_i    <= '0;
    max_y_i    <= '0;
    max_z_i    <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_planes();
    test_axis_planes();
    test_register_extremes();
    test_box_stream(PlanesFrustum, 0, 320, 0);
    test_box_stream(PlanesFrustum, 88, 320, 0);
    test_box_stream(PlanesMixed, 29, 320, 0);
    test_box_stream(PlanesMixed, 0, 320, 80);

    drain_results();
    repeat (Latency + 4) @(posedge clk_i);
    if (vis_expect_q.size() != 0) begin
      report_mismatch($sformatf("%0d verdicts never arrived", vis_expect_q.size()));
    end
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
